FILE: rtl/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;
  localparam int OP_W           = 3;
  localparam int STATUS_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_RECIP = 3'd4,
    OP_MAG   = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  typedef struct packed {
    logic is_div;
    logic divz;
    logic neg_re;
    logic neg_im;
    logic sat;
  } ctrl_t;

endpackage

FILE: rtl/complex_arithmetic_unit.sv
// Top level of the fixed-point complex arithmetic unit.
// Usage: the input channel (in_valid/in_ready) carries one request word with an
// operation code and two complex operands; the result channel (out_valid/out_ready)
// returns one word per request with the real part, imaginary part and status.
// Every operation flows through the same pipeline: a product stage, a sum stage,
// a row of DATA_WIDTH+2 division cells that each resolve one quotient bit, and
// the output register.
// A new word is accepted in every cycle while the receiver takes results, so
// the throughput is one word per cycle; the division cell row sets the latency.
// When the receiver stalls, the whole pipeline holds and in_ready drops in the
// same cycle; a waiting result stays on the output unchanged until taken.
// Results come out in request order.
// Reset clears all valid bits, so the pipeline comes up empty and ready.
// Saturated results report status 1, and a zero divisor returns zero with
// status 2.
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cau_pkg::OP_W-1:0]      in_req_type,
  input  logic signed [DATA_WIDTH-1:0]  in_x_re,
  input  logic signed [DATA_WIDTH-1:0]  in_x_im,
  input  logic signed [DATA_WIDTH-1:0]  in_y_re,
  input  logic signed [DATA_WIDTH-1:0]  in_y_im,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]  out_res_re,
  output logic signed [DATA_WIDTH-1:0]  out_res_im,
  output logic [cau_pkg::STATUS_W-1:0]  out_status
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int OW   = (W > F + 2) ? W : F + 2;
  localparam int PW   = 2 * OW;
  localparam int SW   = PW + 1;
  localparam int DENW = 2 * W;
  localparam int RW   = SW + F;
  localparam int QW   = W + 2;
  localparam int NC   = W + 2;

  logic             en;
  logic             vld_c  [NC+1];
  cau_pkg::ctrl_t   ctrl_c [NC+1];
  logic [DENW-1:0]  den_c  [NC+1];
  logic [RW-1:0]    rre_c  [NC+1];
  logic [RW-1:0]    rim_c  [NC+1];
  logic [QW-1:0]    qre_c  [NC+1];
  logic [QW-1:0]    qim_c  [NC+1];
  logic [W-1:0]     pre_c  [NC+1];
  logic [W-1:0]     pim_c  [NC+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  cau_front #(.W(W), .F(F)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid),
    .op_i   (in_req_type),
    .x_re   (in_x_re),
    .x_im   (in_x_im),
    .y_re   (in_y_re),
    .y_im   (in_y_im),
    .vld_o  (vld_c[0]),
    .ctrl_o (ctrl_c[0]),
    .den_o  (den_c[0]),
    .rre_o  (rre_c[0]),
    .rim_o  (rim_c[0]),
    .pre_o  (pre_c[0]),
    .pim_o  (pim_c[0])
  );

  assign qre_c[0] = '0;
  assign qim_c[0] = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    cau_div_cell #(
      .W(W), .RW(RW), .DENW(DENW), .QW(QW), .SHIFT(NC - 1 - k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (vld_c[k]),
      .ctrl_i (ctrl_c[k]),
      .den_i  (den_c[k]),
      .rre_i  (rre_c[k]),
      .rim_i  (rim_c[k]),
      .qre_i  (qre_c[k]),
      .qim_i  (qim_c[k]),
      .pre_i  (pre_c[k]),
      .pim_i  (pim_c[k]),
      .vld_o  (vld_c[k+1]),
      .ctrl_o (ctrl_c[k+1]),
      .den_o  (den_c[k+1]),
      .rre_o  (rre_c[k+1]),
      .rim_o  (rim_c[k+1]),
      .qre_o  (qre_c[k+1]),
      .qim_o  (qim_c[k+1]),
      .pre_o  (pre_c[k+1]),
      .pim_o  (pim_c[k+1])
    );
  end

  cau_back #(.W(W), .QW(QW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vld_i      (vld_c[NC]),
    .ctrl_i     (ctrl_c[NC]),
    .qre_i      (qre_c[NC]),
    .qim_i      (qim_c[NC]),
    .pre_i      (pre_c[NC]),
    .pim_i      (pim_c[NC]),
    .out_valid  (out_valid),
    .out_res_re (out_res_re),
    .out_res_im (out_res_im),
    .out_status (out_status)
  );

  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not match the output register state");

  a_divz_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == cau_pkg::ST_DIVZ) |-> (out_res_re == '0 && out_res_im == '0))
    else $error("divide-by-zero word carries a nonzero result");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == cau_pkg::ST_OK || out_status == cau_pkg::ST_SAT ||
                   out_status == cau_pkg::ST_DIVZ))
    else $error("output word carries an undefined status");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(vld_c[NC]) && $stable(out_res_re)))
    else $error("pipeline moved while the output was stalled");

endmodule

FILE: rtl/cau_front.sv
// Operand selection, product stage and sum stage feeding the divider cells.
module cau_front #(
  parameter int W = cau_pkg::DATA_WIDTH_DEF,
  parameter int F = cau_pkg::FRAC_BITS_DEF,
  localparam int OW   = (W > F + 2) ? W : F + 2,
  localparam int PW   = 2 * OW,
  localparam int SW   = PW + 1,
  localparam int DENW = 2 * W,
  localparam int RW   = SW + F
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_i,
  input  logic [cau_pkg::OP_W-1:0]   op_i,
  input  logic signed [W-1:0]        x_re,
  input  logic signed [W-1:0]        x_im,
  input  logic signed [W-1:0]        y_re,
  input  logic signed [W-1:0]        y_im,
  output logic                       vld_o,
  output cau_pkg::ctrl_t             ctrl_o,
  output logic [DENW-1:0]            den_o,
  output logic [RW-1:0]              rre_o,
  output logic [RW-1:0]              rim_o,
  output logic [W-1:0]               pre_o,
  output logic [W-1:0]               pim_o
);

  localparam logic [OW-1:0] ONE_U = OW'(1) << F;
  localparam logic signed [SW-1:0] MAXP = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] MINP = -MAXP - SW'(1);

  logic signed [OW-1:0] xr, xi, yr, yi, one;
  logic signed [OW-1:0] a0, a1, a2, a3, b0, b1, b2, b3;
  logic signed [W-1:0]  dr, di;
  logic                 re_sub, im_sub, is_div;

  logic                 vld_a_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [PW-1:0] p0_nxt, p1_nxt, p2_nxt, p3_nxt;
  logic [DENW-1:0]      sq0_r, sq1_r;
  logic                 re_sub_r, im_sub_r, is_div_r;

  logic signed [SW-1:0] vre, vim, shre, shim;
  logic [SW-1:0]        mre, mim;
  logic [DENW-1:0]      den;
  logic [W-1:0]         pre, pim;
  logic                 fre, fim;
  cau_pkg::ctrl_t       ctrl;

  logic                 vld_b_r;
  cau_pkg::ctrl_t       ctrl_r;
  logic [DENW-1:0]      den_r;
  logic [RW-1:0]        rre_r, rim_r;
  logic [W-1:0]         pre_r, pim_r;

  assign xr  = OW'(x_re);
  assign xi  = OW'(x_im);
  assign yr  = OW'(y_re);
  assign yi  = OW'(y_im);
  assign one = signed'(ONE_U);

  always_comb begin
    a0 = '0; a1 = '0; a2 = '0; a3 = '0;
    b0 = '0; b1 = '0; b2 = '0; b3 = '0;
    dr = '0; di = '0;
    re_sub = 1'b0;
    im_sub = 1'b0;
    is_div = 1'b0;
    unique case (cau_pkg::op_t'(op_i)) inside
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        a0 = xr; b0 = one; a1 = yr; b1 = one;
        a2 = xi; b2 = one; a3 = yi; b3 = one;
        re_sub = (cau_pkg::op_t'(op_i) == cau_pkg::OP_SUB);
        im_sub = (cau_pkg::op_t'(op_i) == cau_pkg::OP_SUB);
      end
      cau_pkg::OP_MUL: begin
        a0 = xr; b0 = yr; a1 = xi; b1 = yi;
        a2 = xr; b2 = yi; a3 = xi; b3 = yr;
        re_sub = 1'b1;
      end
      cau_pkg::OP_DIV: begin
        a0 = xr; b0 = yr; a1 = xi; b1 = yi;
        a2 = xi; b2 = yr; a3 = xr; b3 = yi;
        im_sub = 1'b1;
        is_div = 1'b1;
        dr = y_re; di = y_im;
      end
      cau_pkg::OP_RECIP: begin
        a0 = one; b0 = xr; a3 = one; b3 = xi;
        im_sub = 1'b1;
        is_div = 1'b1;
        dr = x_re; di = x_im;
      end
      cau_pkg::OP_MAG: begin
        a0 = xr; b0 = xr; a1 = xi; b1 = xi;
      end
      default: begin
      end
    endcase
  end

  assign p0_nxt = PW'(a0) * PW'(b0);
  assign p1_nxt = PW'(a1) * PW'(b1);
  assign p2_nxt = PW'(a2) * PW'(b2);
  assign p3_nxt = PW'(a3) * PW'(b3);

  always_comb begin
    vre  = re_sub_r ? (SW'(p0_r) - SW'(p1_r)) : (SW'(p0_r) + SW'(p1_r));
    vim  = im_sub_r ? (SW'(p2_r) - SW'(p3_r)) : (SW'(p2_r) + SW'(p3_r));
    den  = sq0_r + sq1_r;
    mre  = vre[SW-1] ? SW'(-vre) : SW'(vre);
    mim  = vim[SW-1] ? SW'(-vim) : SW'(vim);
    shre = vre >>> F;
    shim = vim >>> F;
    fre  = 1'b0;
    fim  = 1'b0;
    pre  = shre[W-1:0];
    pim  = shim[W-1:0];
    if (shre > MAXP) begin
      pre = MAXP[W-1:0];
      fre = 1'b1;
    end else if (shre < MINP) begin
      pre = MINP[W-1:0];
      fre = 1'b1;
    end
    if (shim > MAXP) begin
      pim = MAXP[W-1:0];
      fim = 1'b1;
    end else if (shim < MINP) begin
      pim = MINP[W-1:0];
      fim = 1'b1;
    end
    ctrl.is_div = is_div_r;
    ctrl.divz   = is_div_r && (den == '0);
    ctrl.neg_re = vre[SW-1];
    ctrl.neg_im = vim[SW-1];
    ctrl.sat    = fre | fim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= vld_i;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r     <= p0_nxt;
      p1_r     <= p1_nxt;
      p2_r     <= p2_nxt;
      p3_r     <= p3_nxt;
      sq0_r    <= DENW'(dr) * DENW'(dr);
      sq1_r    <= DENW'(di) * DENW'(di);
      re_sub_r <= re_sub;
      im_sub_r <= im_sub;
      is_div_r <= is_div;
      ctrl_r   <= ctrl;
      den_r    <= den;
      rre_r    <= RW'(mre) << F;
      rim_r    <= RW'(mim) << F;
      pre_r    <= pre;
      pim_r    <= pim;
    end
  end

  assign vld_o  = vld_b_r;
  assign ctrl_o = ctrl_r;
  assign den_o  = den_r;
  assign rre_o  = rre_r;
  assign rim_o  = rim_r;
  assign pre_o  = pre_r;
  assign pim_o  = pim_r;

endmodule

FILE: rtl/cau_div_cell.sv
// One restoring division cell: resolves one quotient bit of both parts.
module cau_div_cell #(
  parameter int W     = cau_pkg::DATA_WIDTH_DEF,
  parameter int RW    = 45,
  parameter int DENW  = 32,
  parameter int QW    = 18,
  parameter int SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  cau_pkg::ctrl_t   ctrl_i,
  input  logic [DENW-1:0]  den_i,
  input  logic [RW-1:0]    rre_i,
  input  logic [RW-1:0]    rim_i,
  input  logic [QW-1:0]    qre_i,
  input  logic [QW-1:0]    qim_i,
  input  logic [W-1:0]     pre_i,
  input  logic [W-1:0]     pim_i,
  output logic             vld_o,
  output cau_pkg::ctrl_t   ctrl_o,
  output logic [DENW-1:0]  den_o,
  output logic [RW-1:0]    rre_o,
  output logic [RW-1:0]    rim_o,
  output logic [QW-1:0]    qre_o,
  output logic [QW-1:0]    qim_o,
  output logic [W-1:0]     pre_o,
  output logic [W-1:0]     pim_o
);

  localparam int CW = (RW > DENW + SHIFT) ? RW : DENW + SHIFT;

  logic [CW-1:0] dsh, cre, cim;
  logic          ge_re, ge_im;
  logic          vld_r;

  assign dsh   = CW'(den_i) << SHIFT;
  assign cre   = CW'(rre_i);
  assign cim   = CW'(rim_i);
  assign ge_re = (cre >= dsh);
  assign ge_im = (cim >= dsh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_o <= ctrl_i;
      den_o  <= den_i;
      rre_o  <= ge_re ? RW'(cre - dsh) : rre_i;
      rim_o  <= ge_im ? RW'(cim - dsh) : rim_i;
      qre_o  <= {qre_i[QW-2:0], ge_re};
      qim_o  <= {qim_i[QW-2:0], ge_im};
      pre_o  <= pre_i;
      pim_o  <= pim_i;
    end
  end

  assign vld_o = vld_r;

endmodule

FILE: rtl/cau_back.sv
// Final saturation, status encoding and the output word register.
module cau_back #(
  parameter int W  = cau_pkg::DATA_WIDTH_DEF,
  parameter int QW = 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  cau_pkg::ctrl_t                ctrl_i,
  input  logic [QW-1:0]                 qre_i,
  input  logic [QW-1:0]                 qim_i,
  input  logic [W-1:0]                  pre_i,
  input  logic [W-1:0]                  pim_i,
  output logic                          out_valid,
  output logic signed [W-1:0]           out_res_re,
  output logic signed [W-1:0]           out_res_im,
  output logic [cau_pkg::STATUS_W-1:0]  out_status
);

  localparam logic [QW-1:0] MAXQ = QW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [W-1:0]  MAXW = MAXQ[W-1:0];
  localparam logic [W-1:0]  MINW = ~MAXW;

  logic [W-1:0]     dre, dim, rre, rim;
  logic             fre, fim;
  cau_pkg::status_t st;
  logic             out_valid_r;
  logic [W-1:0]     res_re_r, res_im_r;
  cau_pkg::status_t status_r;

  always_comb begin
    fre = 1'b0;
    fim = 1'b0;
    if (ctrl_i.neg_re) begin
      dre = W'(-qre_i);
      if (qre_i > MAXQ + QW'(1)) begin
        dre = MINW;
        fre = 1'b1;
      end
    end else begin
      dre = qre_i[W-1:0];
      if (qre_i > MAXQ) begin
        dre = MAXW;
        fre = 1'b1;
      end
    end
    if (ctrl_i.neg_im) begin
      dim = W'(-qim_i);
      if (qim_i > MAXQ + QW'(1)) begin
        dim = MINW;
        fim = 1'b1;
      end
    end else begin
      dim = qim_i[W-1:0];
      if (qim_i > MAXQ) begin
        dim = MAXW;
        fim = 1'b1;
      end
    end
    if (!ctrl_i.is_div) begin
      rre = pre_i;
      rim = pim_i;
      st  = ctrl_i.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end else if (ctrl_i.divz) begin
      rre = '0;
      rim = '0;
      st  = cau_pkg::ST_DIVZ;
    end else begin
      rre = dre;
      rim = dim;
      st  = (fre | fim) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= rre;
      res_im_r <= rim;
      status_r <= st;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_res_re = signed'(res_re_r);
  assign out_res_im = signed'(res_im_r);
  assign out_status = status_r;

endmodule
